/* src/aram_pkg.sv */
package aram_pkg;

  localparam int MAX_RANGES_DEF = 64;

  typedef enum logic [2:0] {
    KIND_GET       = 3'd0,
    KIND_GET_BOUND = 3'd1,
    KIND_SET       = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_HIGHEST   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] stop;
    logic [31:0] attr;
  } entry_t;

endpackage

/* src/address_range_attribute_map_unit.sv */
// channel   | ports                                         | direction
// ----------+-----------------------------------------------+----------
// input     | in_valid in_stall in_kind in_range_start       | in
//           | in_range_end in_attribute                      |
// result    | out_valid out_stall out_value out_found        | out
//           | out_boundary out_status                        |
//
// Queries scan the table one entry at a time through the single read port
// (ST_RD reads, ST_CHK compares); highest start reads only the last entry.
// Set and clear rebuild the table into the spare bank entry by entry (one
// read, then left, insert and right pieces through the one write port);
// a refused update keeps the old bank.
// Reset empties the table at once (entry count zero, no clearing pass).
// in_stall is high while a transaction is in work; one finished result may
// wait in the output register while the next transaction is accepted.
module address_range_attribute_map_unit #(
  parameter int MAX_RANGES = aram_pkg::MAX_RANGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_end,
  input  logic [31:0] in_attribute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_found,
  output logic [63:0] out_boundary,
  output logic        out_status
);
  import aram_pkg::*;

  localparam int AW   = $clog2(MAX_RANGES);
  localparam int CNTW = $clog2(MAX_RANGES + 1);
  localparam int TW   = $clog2(MAX_RANGES + 3);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_CHK   = 9'b000000100,
    ST_EL    = 9'b000001000,
    ST_EN    = 9'b000010000,
    ST_ER    = 9'b000100000,
    ST_TAIL  = 9'b001000000,
    ST_FLUSH = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  entry_t mem [0:(1 << (AW + 1)) - 1];

  state_t          state_r, state_nxt;
  logic            bank_r, bank_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [TW-1:0]   tcnt_r, tcnt_nxt;
  entry_t          hold_r, hold_nxt;
  logic            hold_v_r, hold_v_nxt;
  logic            ins_r, ins_nxt;
  logic            first_r, first_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [63:0]     s_r, s_nxt;
  logic [63:0]     e_r, e_nxt;
  logic [31:0]     a_r, a_nxt;
  logic [31:0]     res_value_r, res_value_nxt;
  logic            res_found_r, res_found_nxt;
  logic [63:0]     res_bound_r, res_bound_nxt;
  logic            res_status_r, res_status_nxt;
  entry_t          rd_q_r;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_value_r, out_value_nxt;
  logic            out_found_r, out_found_nxt;
  logic [63:0]     out_bound_r, out_bound_nxt;
  logic            out_status_r, out_status_nxt;

  logic   rd_en, wr_en, push_en, merge_en, do_ins, flush, last, is_upd;
  entry_t push_data;
  logic [63:0] merge_stop, ps;
  logic [AW-1:0] wr_idx;

  assign in_stall = (state_r != ST_IDLE);
  assign last     = ((CNTW'(idx_r) + CNTW'(1)) == cnt_r);
  assign is_upd   = (kind_r == KIND_SET) || (kind_r == KIND_CLEAR);
  assign ps       = (rd_q_r.start > e_r) ? rd_q_r.start : e_r;
  assign wr_idx   = AW'(tcnt_r - TW'(1));

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    tcnt_nxt       = tcnt_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;
    ins_nxt        = ins_r;
    first_nxt      = first_r;
    kind_nxt       = kind_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    a_nxt          = a_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    res_bound_nxt  = res_bound_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_bound_nxt  = out_bound_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    push_en        = 1'b0;
    merge_en       = 1'b0;
    do_ins         = 1'b0;
    flush          = 1'b0;
    push_data      = '0;
    merge_stop     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          s_nxt          = in_range_start;
          e_nxt          = in_range_end;
          a_nxt          = in_attribute;
          res_value_nxt  = '0;
          res_found_nxt  = 1'b0;
          res_bound_nxt  = '0;
          res_status_nxt = 1'b0;
          idx_nxt        = '0;
          state_nxt      = ST_DONE;
          case (in_kind)
            KIND_GET, KIND_GET_BOUND: begin
              if (cnt_r == '0) begin
                res_bound_nxt = (in_kind == KIND_GET_BOUND) ? '1 : '0;
              end else begin
                state_nxt = ST_RD;
              end
            end
            KIND_HIGHEST: begin
              if (cnt_r != '0) begin
                idx_nxt   = AW'(cnt_r - CNTW'(1));
                state_nxt = ST_RD;
              end
            end
            KIND_SET, KIND_CLEAR: begin
              if (in_range_end > in_range_start) begin
                tcnt_nxt   = '0;
                hold_v_nxt = 1'b0;
                ins_nxt    = (in_kind == KIND_SET);
                first_nxt  = 1'b1;
                state_nxt  = (cnt_r == '0) ? ST_TAIL : ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = is_upd ? ST_EL : ST_CHK;
      end
      ST_CHK: begin
        state_nxt = ST_DONE;
        if (kind_r == KIND_HIGHEST) begin
          res_bound_nxt = rd_q_r.start;
        end else if (rd_q_r.start <= s_r && rd_q_r.stop > s_r) begin
          res_found_nxt = 1'b1;
          res_value_nxt = rd_q_r.attr;
          res_bound_nxt = (kind_r == KIND_GET_BOUND) ? rd_q_r.stop : '0;
        end else if (rd_q_r.start > s_r) begin
          res_bound_nxt = (kind_r == KIND_GET_BOUND) ? rd_q_r.start : '0;
        end else if (last) begin
          res_bound_nxt = (kind_r == KIND_GET_BOUND) ? '1 : '0;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_EL: begin
        if (rd_q_r.start < s_r) begin
          push_en         = 1'b1;
          push_data.start = rd_q_r.start;
          push_data.stop  = (rd_q_r.stop < s_r) ? rd_q_r.stop : s_r;
          push_data.attr  = rd_q_r.attr;
        end
        state_nxt = ST_EN;
      end
      ST_EN: begin
        if (ins_r && (rd_q_r.start >= s_r || rd_q_r.stop > e_r)) begin
          do_ins = 1'b1;
        end
        state_nxt = ST_ER;
      end
      ST_ER: begin
        if (rd_q_r.stop > e_r) begin
          first_nxt = 1'b0;
          if (first_r && kind_r == KIND_SET && ps == e_r && rd_q_r.attr == a_r &&
              hold_v_r) begin
            merge_en   = 1'b1;
            merge_stop = rd_q_r.stop;
          end else begin
            push_en         = 1'b1;
            push_data.start = ps;
            push_data.stop  = rd_q_r.stop;
            push_data.attr  = rd_q_r.attr;
          end
        end
        if (last) begin
          state_nxt = ST_TAIL;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_TAIL: begin
        do_ins    = ins_r;
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        flush = 1'b1;
        if (tcnt_r > TW'(MAX_RANGES)) begin
          res_status_nxt = 1'b1;
        end else begin
          bank_nxt = ~bank_r;
          cnt_nxt  = CNTW'(tcnt_r);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_found_nxt  = res_found_r;
          out_bound_nxt  = res_bound_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (do_ins) begin
      ins_nxt = 1'b0;
      if (hold_v_r && hold_r.stop == s_r && hold_r.attr == a_r) begin
        merge_en   = 1'b1;
        merge_stop = e_r;
      end else begin
        push_en         = 1'b1;
        push_data.start = s_r;
        push_data.stop  = e_r;
        push_data.attr  = a_r;
      end
    end

    if (push_en) begin
      hold_nxt   = push_data;
      hold_v_nxt = 1'b1;
      tcnt_nxt   = tcnt_r + TW'(1);
    end
    if (merge_en) begin
      hold_nxt.stop = merge_stop;
    end
  end

  assign wr_en = (push_en || flush) && hold_v_r && (tcnt_r <= TW'(MAX_RANGES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~bank_r, wr_idx}] <= hold_r;
    end
    if (rd_en) begin
      rd_q_r <= mem[{bank_r, idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hold_v_r    <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    tcnt_r       <= tcnt_nxt;
    hold_r       <= hold_nxt;
    ins_r        <= ins_nxt;
    first_r      <= first_nxt;
    kind_r       <= kind_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    a_r          <= a_nxt;
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    res_bound_r  <= res_bound_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_bound_r  <= out_bound_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_found    = out_found_r;
  assign out_boundary = out_bound_r;
  assign out_status   = out_status_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_RANGES))
    else $error("entry count above capacity");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_EL || state_r == ST_EN || state_r == ST_ER ||
               state_r == ST_TAIL || state_r == ST_FLUSH))
    else $error("table write outside update");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_r != bank_nxt) |-> (state_r == ST_FLUSH && tcnt_r <= TW'(MAX_RANGES)))
    else $error("bank swap outside flush");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("result lost on completion");
`endif

endmodule

/* sim/testbench.sv */
module testbench;
  import aram_pkg::*;

  localparam int DEPTH = MAX_RANGES_DEF;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 4 * DEPTH + 20;
  localparam logic [2:0] KIND_BAD = 3'd5;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] rs;
    logic [63:0] re;
    logic [31:0] attr;
  } op_t;

  typedef struct {
    logic [31:0] value;
    logic        found;
    logic [63:0] boundary;
    logic        status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_range_start = '0;
  logic [63:0] in_range_end = '0;
  logic [31:0] in_attribute = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] out_value;
  logic        out_found;
  logic [63:0] out_boundary;
  logic        out_status;

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  entry_t map_tab[DEPTH];
  int     map_cnt = 0;
  int     errors = 0;
  int     cycle = 0;
  int     accepted = 0;
  int     checked = 0;
  int     full_refusals = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles = 0;
  bit     all_queued = 0;

  address_range_attribute_map_unit u_top (.*);

  always #5 clk = ~clk;

  function automatic logic map_update(logic [63:0] s, logic [63:0] e, logic do_set,
                                      logic [31:0] a);
    entry_t tmp[$];
    entry_t x;
    logic   first_right;
    first_right = 1'b1;
    if (e <= s) return 1'b0;
    for (int i = 0; i < map_cnt; i++)
      if (map_tab[i].start < s) begin
        x = map_tab[i];
        if (x.stop > s) x.stop = s;
        tmp.push_back(x);
      end
    if (do_set) begin
      if (tmp.size() > 0 && tmp[$].stop == s && tmp[$].attr == a) tmp[$].stop = e;
      else tmp.push_back('{s, e, a});
    end
    for (int i = 0; i < map_cnt; i++)
      if (map_tab[i].stop > e) begin
        x = map_tab[i];
        if (x.start < e) x.start = e;
        if (first_right && do_set && x.start == e && x.attr == a && tmp.size() > 0)
          tmp[$].stop = x.stop;
        else tmp.push_back(x);
        first_right = 1'b0;
      end
    if (tmp.size() > DEPTH) return 1'b1;
    foreach (tmp[i]) map_tab[i] = tmp[i];
    map_cnt = tmp.size();
    return 1'b0;
  endfunction

  function automatic reply_t map_predict(op_t op);
    reply_t r;
    logic   hit;
    r = '{default: '0};
    hit = 1'b0;
    case (op.kind)
      KIND_GET, KIND_GET_BOUND: begin
        r.boundary = '1;
        for (int i = 0; i < map_cnt; i++) begin
          if (map_tab[i].start <= op.rs && map_tab[i].stop > op.rs) begin
            hit = 1'b1;
            r.value = map_tab[i].attr;
            r.boundary = map_tab[i].stop;
            break;
          end
          if (map_tab[i].start > op.rs) begin
            r.boundary = map_tab[i].start;
            break;
          end
        end
        r.found = hit;
        if (op.kind == KIND_GET) r.boundary = '0;
      end
      KIND_SET: r.status = map_update(op.rs, op.re, 1'b1, op.attr);
      KIND_CLEAR: r.status = map_update(op.rs, op.re, 1'b0, '0);
      KIND_HIGHEST: if (map_cnt > 0) r.boundary = map_tab[map_cnt-1].start;
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_op(logic [2:0] k, logic [63:0] s, logic [63:0] e, logic [31:0] a);
    pending_ops.push_back('{k, s, e, a});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small address window so ranges collide, merge and split often.
  function automatic logic [63:0] near_addr();
    return 64'h1000 + $urandom_range(0, 400);
  endfunction

  task automatic add_random_op();
    int          sel;
    logic [63:0] s;
    logic [63:0] e;
    logic [31:0] a;
    sel = $urandom_range(0, 99);
    s = near_addr();
    e = s + $urandom_range(1, 40);
    a = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) a = $urandom;
    if (sel < 30) add_op(KIND_SET, s, e, a);
    else if (sel < 45) add_op(KIND_CLEAR, s, e, '0);
    else if (sel < 65) add_op(KIND_GET, s, rand64(), $urandom);
    else if (sel < 85) add_op(KIND_GET_BOUND, s, rand64(), $urandom);
    else if (sel < 90) add_op(KIND_HIGHEST, rand64(), rand64(), $urandom);
    else if (sel < 93) add_op(3'($urandom_range(5, 7)), rand64(), rand64(), $urandom);
    else if (sel < 97) add_op(3'($urandom_range(0, 4)), rand64(), rand64(), $urandom);
    else add_op(KIND_SET, e, s, $urandom);
  endtask

  // Fill the table with many small separated ranges to reach the capacity limit.
  task automatic add_fill();
    for (int i = 0; i < DEPTH + 4; i++)
      add_op(KIND_SET, 64'h1000 + 8 * i, 64'h1000 + 8 * i + 3, $urandom_range(0, 3));
    add_op(KIND_CLEAR, 64'h1001, 64'h1002, '0);
    add_op(KIND_SET, 64'h1005, 64'h1006, 32'h77);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_replies.size() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("Timeout at cycle %0d", cycle);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(map_predict(pending_ops.pop_front()));
        accepted <= accepted + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(in_valid && !in_stall && pending_ops.size() == 0)) begin
          in_valid <= 1'b1;
          in_kind <= pending_ops[0].kind;
          in_range_start <= pending_ops[0].rs;
          in_range_end <= pending_ops[0].re;
          in_attribute <= pending_ops[0].attr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t unexpected transaction: value %h boundary %h", $time,
                   out_value, out_boundary);
          errors <= errors + 1;
        end else begin
          exp_r = expected_replies.pop_front();
          checked <= checked + 1;
          if (exp_r.status) full_refusals <= full_refusals + 1;
          if (exp_r.value !== out_value || exp_r.found !== out_found ||
              exp_r.boundary !== out_boundary || exp_r.status !== out_status) begin
            $display("%0t mismatch: expected value %h found %b boundary %h status %b",
                     $time, exp_r.value, exp_r.found, exp_r.boundary, exp_r.status);
            $display("%0t           actual   value %h found %b boundary %h status %b",
                     $time, out_value, out_found, out_boundary, out_status);
            errors <= errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    add_op(KIND_HIGHEST, '0, '0, '0);
    add_op(KIND_GET_BOUND, '0, '0, '0);
    add_op(KIND_SET, 64'h10, 64'h20, 32'hFFFF_FFFF);
    add_op(KIND_SET, 64'h20, 64'h30, 32'hFFFF_FFFF);
    add_op(KIND_SET, 64'h08, 64'h10, 32'hFFFF_FFFF);
    add_op(KIND_SET, 64'h18, 64'h1C, 32'h5);
    add_op(KIND_CLEAR, 64'h24, 64'h26, '0);
    add_op(KIND_SET, 64'h40, 64'h40, 32'h9);
    add_op(KIND_CLEAR, 64'h50, 64'h10, '0);
    add_op(KIND_SET, 64'hFFFF_FFFF_FFFF_FFF0, '1, 32'h0);
    add_op(KIND_SET, '0, 64'h1, 32'hA5A5_5A5A);
    add_op(KIND_GET, 64'h18, '0, '0);
    add_op(KIND_GET_BOUND, 64'h18, '0, '0);
    add_op(KIND_GET_BOUND, 64'h30, '0, '0);
    add_op(KIND_GET_BOUND, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
    add_op(KIND_GET_BOUND, '1, '0, '0);
    add_op(KIND_HIGHEST, '1, '1, '1);
    add_op(KIND_BAD, '1, '1, '1);
    add_op(3'd7, '1, '1, '1);
    add_op(KIND_CLEAR, '0, '1, '1);
    add_op(KIND_HIGHEST, '0, '0, '0);
    add_fill();
    add_op(KIND_CLEAR, '0, '1, '0);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 25 : 0;
      for (int i = 0; i < 400; i++) add_random_op();
      if (ph == 1) add_fill();
      if (ph == 2) hold_cycles = 3000;
      wait_drained();
      add_op(KIND_CLEAR, '0, '1, '0);
    end
    all_queued = 1;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d transactions, %0d results checked, %0d capacity refusals.",
             accepted, checked, full_refusals);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
